// ===== rtl/rph_pkg.sv =====
// rph_pkg: shared widths, operation codes, register indexes and reset values
// for the rolling polynomial hash core, plus the divider request/response types.
// No dependencies.
package rph_pkg;

  localparam int HASH_W  = 31;   // hash, power, inverse, base and modulus
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = 64;   // multiplier product and divider dividend
  localparam int MUL_W   = 32;   // signed multiplier operands
  localparam int STEPS_W = 7;    // divider step count, up to PROD_W
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_SKIP    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // register index, taken from the word address bit
  localparam logic CFG_IDX_BASE = 1'b0;
  localparam logic CFG_IDX_MOD  = 1'b1;

  localparam logic [HASH_W-1:0] BASE_RESET = 31'd256;
  localparam logic [HASH_W-1:0] MOD_RESET  = 31'd1000003;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;   // left aligned: top 'steps' bits are used
    logic [STEPS_W-1:0] steps;
    logic [HASH_W-1:0] divisor;
  } rph_div_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] remainder;  // zero when the divisor is zero
    logic [HASH_W-1:0] quotient;   // low bits of the quotient
  } rph_div_rsp_t;

endpackage

// ===== rtl/rph_divider.sv =====
// rph_divider: restoring radix-2 divider, one quotient bit per cycle.
// Reduces a left-aligned dividend by a 31-bit divisor. Depends on rph_pkg.
module rph_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rph_pkg::rph_div_req_t req,
  output rph_pkg::rph_div_rsp_t rsp
);
  import rph_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEPS_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]  x_r, x_nxt;
  logic [HASH_W-1:0]  rem_r, rem_nxt;
  logic [HASH_W-1:0]  dvs_r, dvs_nxt;
  logic [HASH_W:0]    trial;
  logic [HASH_W:0]    diff;
  logic               fits;

  assign trial = {rem_r, x_r[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      x_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      x_nxt   = {x_r[PROD_W-2:0], fits};
      rem_nxt = fits ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEPS_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = (dvs_r == '0) ? '0 : rem_r;
  assign rsp.quotient  = x_r[HASH_W-1:0];

endmodule

// ===== rtl/rolling_polynomial_hash_core.sv =====
// rolling_polynomial_hash_core: Rabin-Karp window hash with configurable base and
// modulus; one shared multiplier and one bit-serial divider under a sequencer.
// Depends on rph_pkg and rph_divider.
//
//   port group | dir | handshake             | word
//   in_        | in  | in_valid / in_ready   | operation, byte_value
//   out_       | out | out_valid / out_ready | hash_value
//   cfg_       | in  | APB write/read        | 0 hash_base, 1 hash_modulus
//
// Append and skip run chains of registered multiplies, each product reduced in the
// divider at one bit per cycle. Restart reduces the base and then runs extended
// Euclid iterations (up to ~45 for a 31-bit modulus); the unused code and a restart
// with modulus 0 or 1 go straight to the output. rst_n is synchronous. in_ready is
// high only between words; a finished hash parks in the output register, so a
// stalled out_ side holds the sequencer only when a second result is ready.
module rolling_polynomial_hash_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rph_pkg::OP_W-1:0]     in_operation,
  input  logic [rph_pkg::BYTE_W-1:0]   in_byte_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rph_pkg::HASH_W-1:0]   out_hash_value,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rph_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [rph_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [rph_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import rph_pkg::*;

  localparam int STEPS_PROD = 62;   // products stay below 2^62
  localparam int STEPS_BYTE = 39;   // byte times a residue
  localparam int STEPS_SUM  = 32;   // hash + modulus - term
  localparam int STEPS_WORD = 31;
  localparam int SH_PROD    = PROD_W - STEPS_PROD;
  localparam int SH_BYTE    = PROD_W - STEPS_BYTE;
  localparam int SH_SUM     = PROD_W - STEPS_SUM;
  localparam int SH_WORD    = PROD_W - STEPS_WORD;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_AP_MH   = 5'd1;
  localparam logic [4:0] ST_AP_RH   = 5'd2;
  localparam logic [4:0] ST_AP_MP   = 5'd3;
  localparam logic [4:0] ST_AP_RP   = 5'd4;
  localparam logic [4:0] ST_SK_MP   = 5'd5;
  localparam logic [4:0] ST_SK_RP   = 5'd6;
  localparam logic [4:0] ST_SK_MS   = 5'd7;
  localparam logic [4:0] ST_SK_RS   = 5'd8;
  localparam logic [4:0] ST_SK_RH   = 5'd9;
  localparam logic [4:0] ST_RS_RA   = 5'd10;
  localparam logic [4:0] ST_EU_TEST = 5'd11;
  localparam logic [4:0] ST_EU_DIV  = 5'd12;
  localparam logic [4:0] ST_EU_MUL  = 5'd13;
  localparam logic [4:0] ST_EU_UPD  = 5'd14;
  localparam logic [4:0] ST_EU_FIX  = 5'd15;
  localparam logic [4:0] ST_DONE    = 5'd16;

  logic [4:0]         state_r, state_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]  base_r, base_nxt;
  logic [HASH_W-1:0]  mod_r, mod_nxt;
  logic [HASH_W-1:0]  wh_r, wh_nxt;
  logic [HASH_W-1:0]  bp_r, bp_nxt;
  logic [HASH_W-1:0]  inv_r, inv_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [HASH_W-1:0]  sub_r, sub_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [HASH_W-1:0]  eu_a_r, eu_a_nxt;
  logic [HASH_W-1:0]  eu_m_r, eu_m_nxt;
  logic [HASH_W-1:0]  eu_q_r, eu_q_nxt;
  logic [MUL_W-1:0]   eu_x0_r, eu_x0_nxt;
  logic [MUL_W-1:0]   eu_x1_r, eu_x1_nxt;
  logic [HASH_W-1:0]  out_hash_r, out_hash_nxt;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]  prod_u;
  logic [STEPS_SUM-1:0] skip_sum;
  logic [MUL_W+1:0]   eu_upd;
  logic [MUL_W:0]     fix_sum;
  logic [MUL_W:0]     fix_val;
  logic               cfg_wr;
  logic               red_state;
  logic               red_done;
  rph_div_req_t       div_req;
  rph_div_rsp_t       div_rsp;

  rph_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_MOD) ? {1'b0, mod_r} : {1'b0, base_r};

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = $signed({1'b0, wh_r});
    mul_b = $signed({1'b0, base_r});
    unique case (state_r)
      ST_AP_MP: begin
        mul_a = $signed({1'b0, bp_r});
      end
      ST_SK_MP: begin
        mul_a = $signed({1'b0, bp_r});
        mul_b = $signed({1'b0, inv_r});
      end
      ST_SK_MS: begin
        mul_a = $signed({{(MUL_W-BYTE_W){1'b0}}, byte_r});
        mul_b = $signed({1'b0, bp_r});
      end
      ST_EU_MUL: begin
        mul_a = $signed({1'b0, eu_q_r});
        mul_b = $signed(eu_x0_r);
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_u   = $unsigned(prod_r);
  assign skip_sum = {1'b0, wh_r} + {1'b0, mod_r} - {1'b0, sub_r};

  // x0' = x1 - q*x0; coefficients stay within the modulus in magnitude
  assign eu_upd  = {{2{eu_x1_r[MUL_W-1]}}, eu_x1_r} - $unsigned(prod_r[MUL_W+1:0]);
  assign fix_sum = eu_x1_r[MUL_W-1] ? ({eu_x1_r[MUL_W-1], eu_x1_r} + {2'b0, mod_r})
                                    : {eu_x1_r[MUL_W-1], eu_x1_r};
  assign fix_val = (fix_sum >= {2'b0, mod_r}) ? (fix_sum - {2'b0, mod_r}) : fix_sum;

  assign red_state = (state_r == ST_AP_RH) || (state_r == ST_AP_RP) ||
                     (state_r == ST_SK_RP) || (state_r == ST_SK_RS) ||
                     (state_r == ST_SK_RH) || (state_r == ST_RS_RA) ||
                     (state_r == ST_EU_DIV);
  assign red_done  = started_r & div_rsp.done;

  // divider request: dividend left aligned for the step count of each reduction
  always_comb begin
    div_req.start    = red_state & ~started_r;
    div_req.divisor  = mod_r;
    div_req.steps    = STEPS_W'(STEPS_PROD);
    div_req.dividend = prod_u << SH_PROD;
    unique case (state_r)
      ST_AP_RH: begin
        div_req.dividend = (prod_u + PROD_W'(byte_r)) << SH_PROD;
      end
      ST_SK_RS: begin
        div_req.steps    = STEPS_W'(STEPS_BYTE);
        div_req.dividend = prod_u << SH_BYTE;
      end
      ST_SK_RH: begin
        div_req.steps    = STEPS_W'(STEPS_SUM);
        div_req.dividend = PROD_W'(skip_sum) << SH_SUM;
      end
      ST_RS_RA: begin
        div_req.steps    = STEPS_W'(STEPS_WORD);
        div_req.dividend = PROD_W'(base_r) << SH_WORD;
      end
      ST_EU_DIV: begin
        div_req.steps    = STEPS_W'(STEPS_WORD);
        div_req.dividend = PROD_W'(eu_a_r) << SH_WORD;
        div_req.divisor  = eu_m_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    base_nxt      = base_r;
    mod_nxt       = mod_r;
    wh_nxt        = wh_r;
    bp_nxt        = bp_r;
    inv_nxt       = inv_r;
    byte_nxt      = byte_r;
    sub_nxt       = sub_r;
    prod_nxt      = prod_r;
    eu_a_nxt      = eu_a_r;
    eu_m_nxt      = eu_m_r;
    eu_q_nxt      = eu_q_r;
    eu_x0_nxt     = eu_x0_r;
    eu_x1_nxt     = eu_x1_r;
    out_hash_nxt  = out_hash_r;

    if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_IDX_MOD) begin
        mod_nxt = cfg_pwdata[HASH_W-1:0];
      end else begin
        base_nxt = cfg_pwdata[HASH_W-1:0];
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (div_req.start) begin
      started_nxt = 1'b1;
    end
    if (red_done) begin
      started_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_byte_value;
          unique case (in_operation)
            OP_APPEND: state_nxt = ST_AP_MH;
            OP_SKIP:   state_nxt = ST_SK_MP;
            OP_RESTART: begin
              wh_nxt = '0;
              bp_nxt = HASH_W'(1);
              if (mod_r <= HASH_W'(1)) begin
                inv_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_RS_RA;
              end
            end
            OP_NONE:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_AP_MH: begin
        prod_nxt  = mul_p;
        state_nxt = ST_AP_RH;
      end
      ST_AP_RH: begin
        if (red_done) begin
          wh_nxt    = div_rsp.remainder;
          state_nxt = ST_AP_MP;
        end
      end
      ST_AP_MP: begin
        prod_nxt  = mul_p;
        state_nxt = ST_AP_RP;
      end
      ST_AP_RP: begin
        if (red_done) begin
          bp_nxt    = div_rsp.remainder;
          state_nxt = ST_DONE;
        end
      end
      ST_SK_MP: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SK_RP;
      end
      ST_SK_RP: begin
        if (red_done) begin
          bp_nxt    = div_rsp.remainder;
          state_nxt = ST_SK_MS;
        end
      end
      ST_SK_MS: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SK_RS;
      end
      ST_SK_RS: begin
        if (red_done) begin
          sub_nxt   = div_rsp.remainder;
          state_nxt = ST_SK_RH;
        end
      end
      ST_SK_RH: begin
        if (red_done) begin
          wh_nxt    = div_rsp.remainder;
          state_nxt = ST_DONE;
        end
      end
      ST_RS_RA: begin
        if (red_done) begin
          eu_a_nxt  = div_rsp.remainder;
          eu_m_nxt  = mod_r;
          eu_x0_nxt = '0;
          eu_x1_nxt = MUL_W'(1);
          state_nxt = ST_EU_TEST;
        end
      end
      ST_EU_TEST: begin
        // zero remainder or common factor: no inverse
        priority if (eu_a_r == '0) begin
          inv_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (eu_a_r == HASH_W'(1)) begin
          state_nxt = ST_EU_FIX;
        end else if (eu_m_r == '0) begin
          inv_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_EU_DIV;
        end
      end
      ST_EU_DIV: begin
        if (red_done) begin
          eu_q_nxt  = div_rsp.quotient;
          eu_m_nxt  = div_rsp.remainder;
          eu_a_nxt  = eu_m_r;
          state_nxt = ST_EU_MUL;
        end
      end
      ST_EU_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_EU_UPD;
      end
      ST_EU_UPD: begin
        eu_x0_nxt = eu_upd[MUL_W-1:0];
        eu_x1_nxt = eu_x0_r;
        state_nxt = ST_EU_TEST;
      end
      ST_EU_FIX: begin
        inv_nxt   = fix_val[HASH_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = wh_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      mod_r       <= MOD_RESET;
      wh_r        <= '0;
      bp_r        <= HASH_W'(1);
      inv_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      mod_r       <= mod_nxt;
      wh_r        <= wh_nxt;
      bp_r        <= bp_nxt;
      inv_r       <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    sub_r      <= sub_nxt;
    prod_r     <= prod_nxt;
    eu_a_r     <= eu_a_nxt;
    eu_m_r     <= eu_m_nxt;
    eu_q_r     <= eu_q_nxt;
    eu_x0_r    <= eu_x0_nxt;
    eu_x1_r    <= eu_x1_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

// ===== verif/rolling_polynomial_hash_core_tb.sv =====
// rolling_polynomial_hash_core_tb: self-checking bench for the rolling hash core.
// Predicts each hash word, drives valid/ready and APB writes with random idling.
// Depends on rph_pkg and rolling_polynomial_hash_core.
module rolling_polynomial_hash_core_tb;
  import rph_pkg::*;

  localparam int unsigned QUIET_LIMIT = 10000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_NONE;
  logic [BYTE_W-1:0] in_byte_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [HASH_W-1:0] out_hash_value;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  rolling_polynomial_hash_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_hash_value(out_hash_value),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [HASH_W-1:0] cfg_base = BASE_RESET;
  logic [HASH_W-1:0] cfg_modulus = MOD_RESET;
  logic [HASH_W-1:0] pred_hash = '0;
  logic [HASH_W-1:0] pred_power = 31'd1;
  logic [HASH_W-1:0] pred_inverse = '0;

  logic [HASH_W-1:0] pending_hashes[$];
  logic [HASH_W-1:0] expected_hash;

  bit idle_enable = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned settings_used = 0;

  function automatic logic [HASH_W-1:0] mod_reduce(logic [63:0] x, logic [HASH_W-1:0] m);
    if (m == 0) return '0;
    return HASH_W'(x % m);
  endfunction

  // extended Euclid; zero when the base has no inverse
  function automatic logic [HASH_W-1:0] inverse_of_base(logic [HASH_W-1:0] b,
                                                        logic [HASH_W-1:0] m);
    longint rem_a, rem_b, coef_a, coef_b, quo, tmp, full_mod;
    full_mod = longint'(m);
    if (full_mod <= 1) return '0;
    rem_a = longint'(b % m);
    if (rem_a == 0) return '0;
    rem_b = full_mod;
    coef_a = 1;
    coef_b = 0;
    while (rem_a > 1) begin
      if (rem_b == 0) return '0;
      quo = rem_a / rem_b;
      tmp = rem_b;
      rem_b = rem_a % rem_b;
      rem_a = tmp;
      tmp = coef_b;
      coef_b = coef_a - quo * coef_b;
      coef_a = tmp;
    end
    coef_a = coef_a % full_mod;
    if (coef_a < 0) coef_a = coef_a + full_mod;
    return HASH_W'(coef_a);
  endfunction

  function automatic logic [HASH_W-1:0] next_window_hash(logic [OP_W-1:0] op,
                                                         logic [BYTE_W-1:0] b);
    logic [63:0] h, p, sub;
    case (op)
      OP_APPEND: begin
        h = mod_reduce(pred_hash, cfg_modulus);
        p = mod_reduce(pred_power, cfg_modulus);
        pred_hash = mod_reduce(h * cfg_base + b, cfg_modulus);
        pred_power = mod_reduce(p * cfg_base, cfg_modulus);
      end
      OP_SKIP: begin
        p = mod_reduce(pred_power, cfg_modulus);
        p = mod_reduce(p * pred_inverse, cfg_modulus);
        pred_power = HASH_W'(p);
        h = mod_reduce(pred_hash, cfg_modulus);
        sub = mod_reduce(b * p, cfg_modulus);
        pred_hash = mod_reduce(h + cfg_modulus - sub, cfg_modulus);
      end
      OP_RESTART: begin
        pred_hash = '0;
        pred_power = 31'd1;
        pred_inverse = inverse_of_base(cfg_base, cfg_modulus);
      end
      default: ;
    endcase
    return pred_hash;
  endfunction

  function automatic logic [HASH_W-1:0] pick_prime();
    case ($urandom_range(0, 7))
      0: return 31'd3;
      1: return 31'd7;
      2: return 31'd101;
      3: return 31'd257;
      4: return 31'd65521;
      5: return 31'd1000003;
      6: return 31'd1000000007;
      default: return 31'd2147483647;
    endcase
  endfunction

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash word: expected none, got %0d", $time, out_hash_value);
        error_count++;
      end else begin
        expected_hash = pending_hashes.pop_front();
        hashes_checked++;
        if (out_hash_value !== expected_hash) begin
          $display("%0t: hash_value mismatch: expected %0d, got %0d",
                   $time, expected_hash, out_hash_value);
          error_count++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d hashes outstanding",
               $time, QUIET_LIMIT, pending_hashes.size());
      $display("rolling_polynomial_hash_core regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_byte_value <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_hashes.push_back(next_window_hash(op, b));
    words_sent++;
    if (op == OP_RESTART) restarts_sent++;
  endtask

  // every word returns a hash, so an empty queue means the core is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hashes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == CFG_IDX_BASE) cfg_base = value[HASH_W-1:0];
    else cfg_modulus = value[HASH_W-1:0];
  endtask

  task automatic set_both(input logic [CFG_DW-1:0] base_word,
                          input logic [CFG_DW-1:0] mod_word);
    write_reg(CFG_IDX_BASE, base_word);
    write_reg(CFG_IDX_MOD, mod_word);
    settings_used++;
  endtask

  task automatic apply_random_setting();
    logic [CFG_DW-1:0] mod_word, base_word;
    logic [HASH_W-1:0] m;
    case ($urandom_range(0, 9))
      0: mod_word = $urandom;                          // arbitrary, mostly composite
      1: mod_word = CFG_DW'($urandom_range(0, 4));
      default: mod_word = {1'b0, pick_prime()};
    endcase
    mod_word[31] = ($urandom_range(0, 1) == 1);
    m = mod_word[HASH_W-1:0];
    case ($urandom_range(0, 7))
      0: base_word = $urandom;                         // may exceed or share a factor
      1: base_word = CFG_DW'($urandom_range(0, 1));
      default: base_word = (m > 3) ? CFG_DW'($urandom_range(2, m - 1)) : 32'd2;
    endcase
    base_word[31] = ($urandom_range(0, 1) == 1);
    case ($urandom_range(0, 5))
      0: write_reg(CFG_IDX_MOD, mod_word);
      1: write_reg(CFG_IDX_BASE, base_word);
      2: begin
        write_reg(CFG_IDX_MOD, mod_word);
        write_reg(CFG_IDX_BASE, base_word);
      end
      default: begin
        write_reg(CFG_IDX_BASE, base_word);
        write_reg(CFG_IDX_MOD, mod_word);
      end
    endcase
    settings_used++;
  endtask

  // mostly a sliding window (append until full, then skip oldest), some noise
  task automatic run_window_phase(input int unsigned word_count);
    logic [BYTE_W-1:0] window[$];
    logic [BYTE_W-1:0] b;
    logic [OP_W-1:0] op;
    int unsigned depth, sent;
    depth = $urandom_range(1, 12);
    sent = 0;
    apply_random_setting();
    // no restart keeps the old window under the new registers
    if ($urandom_range(0, 3) != 0) begin
      send_word(OP_RESTART, BYTE_W'($urandom));
      sent++;
    end
    while (sent < word_count) begin
      case ($urandom_range(0, 15))
        0: begin
          op = OP_W'($urandom);
          b = BYTE_W'($urandom);
          send_word(op, b);
          if (op == OP_RESTART) window.delete();
          else if (op == OP_APPEND) window.push_back(b);
          else if (op == OP_SKIP && window.size() != 0) void'(window.pop_front());
          if (op != OP_NONE) sent++;
        end
        1: begin
          send_word(OP_RESTART, BYTE_W'($urandom));
          window.delete();
          sent++;
        end
        default: begin
          if (window.size() < depth) begin
            b = BYTE_W'($urandom);
            send_word(OP_APPEND, b);
            window.push_back(b);
          end else begin
            b = window.pop_front();
            send_word(OP_SKIP, b);
          end
          sent++;
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_reset_state();
    send_word(OP_NONE, 8'h00);
    send_word(OP_SKIP, 8'hAB);       // inverse still zero before any restart
    send_word(OP_APPEND, 8'hFF);
    send_word(OP_APPEND, 8'h00);
    send_word(OP_RESTART, 8'h5A);
    send_word(OP_APPEND, 8'h80);
    send_word(OP_APPEND, 8'h7F);
    send_word(OP_SKIP, 8'h80);
    send_word(OP_NONE, 8'hFF);
    wait_idle();
  endtask

  task automatic test_extreme_setting();
    set_both(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    send_word(OP_RESTART, 8'h00);
    send_word(OP_APPEND, 8'hFF);
    send_word(OP_APPEND, 8'hFF);
    send_word(OP_SKIP, 8'hFF);
    wait_idle();
  endtask

  // modulus zero and one, lowest legal pair, base a multiple, base sharing a factor
  task automatic test_degenerate_moduli();
    logic [CFG_DW-1:0] base_list[5];
    logic [CFG_DW-1:0] mod_list[5];
    base_list = '{32'd5, 32'd7, 32'd2, 32'd14, 32'd6};
    mod_list = '{32'd0, 32'd1, 32'd3, 32'd7, 32'd9};
    for (int i = 0; i < 5; i++) begin
      set_both(base_list[i], mod_list[i]);
      send_word(OP_RESTART, 8'h3C);
      if (i != 1) send_word(OP_APPEND, 8'hC3);
      send_word(OP_SKIP, 8'hC3);
      wait_idle();
    end
  endtask

  task automatic test_register_change();
    set_both(32'd256, 32'd1000003);
    send_word(OP_RESTART, 8'h00);
    send_word(OP_APPEND, 8'h41);
    send_word(OP_APPEND, 8'h42);
    wait_idle();
    write_reg(CFG_IDX_MOD, 32'd101);
    settings_used++;
    send_word(OP_SKIP, 8'h41);
    wait_idle();
  endtask

  task automatic test_random_windows();
    repeat (10) run_window_phase(95);
  endtask

  task automatic test_steady_flow();
    idle_enable = 1'b0;
    repeat (2) run_window_phase(75);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extreme_setting();
    test_degenerate_moduli();
    test_register_change();
    test_random_windows();
    test_steady_flow();
    wait_idle();
    repeat (300) @(posedge clk);
    if (pending_hashes.size() != 0) begin
      $display("%0t: hash words missing: expected %0d more, got none",
               $time, pending_hashes.size());
      error_count++;
    end
    $display("Sent %0d words (%0d restarts) under %0d register settings;",
             words_sent, restarts_sent, settings_used);
    $display("checked %0d hash words, %0d errors.", hashes_checked, error_count);
    if (error_count == 0) begin
      $display("rolling_polynomial_hash_core regression: pass");
    end else begin
      $display("rolling_polynomial_hash_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rph_pkg.sv
rtl/rph_divider.sv
rtl/rolling_polynomial_hash_core.sv
verif/rolling_polynomial_hash_core_tb.sv
